// ===== rtl/ptsd_pkg.sv =====
// Shared constants, codes and transaction types for the pulse train start detector.
// No dependencies; every other file but ptsd_ram imports this package.
package ptsd_pkg;

  // Frame storage
  localparam int MAX_FRAME = 4096;
  localparam int ADDR_W    = $clog2(MAX_FRAME);
  localparam int CNT_W     = ADDR_W + 1;

  // Sample and magnitude widths
  localparam int SAMPLE_W = 16;
  localparam int SQ_W     = 2 * SAMPLE_W - 1;
  localparam int MAG_W    = 2 * SAMPLE_W;
  localparam int THR_W    = MAG_W + 2;
  localparam int HI_W     = MAG_W + 4;

  // Configuration and result widths
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam int NEED_W    = 2 * CFG_W + 1;
  localparam int START_W   = 14;
  localparam int STATUS_W  = 2;
  localparam int START_MAX = (1 << START_W) - 1;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SHORT   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_EDGE = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXTRA_PULSES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_PERIOD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_SPAN    = 2'd3;

  // Reset values of the registers
  localparam logic [CFG_W-1:0] RST_PULSE_COUNT  = 12'd1;
  localparam logic [CFG_W-1:0] RST_EXTRA_PULSES = 12'd0;
  localparam logic [CFG_W-1:0] RST_PULSE_PERIOD = 12'd64;
  localparam logic [CFG_W-1:0] RST_HIGH_SPAN    = 12'd16;

  // One closed frame handed from front to back
  typedef struct packed {
    logic [CNT_W-1:0] n;
    logic [MAG_W-1:0] peak;
  } desc_t;

  // Register file contents
  typedef struct packed {
    logic [CFG_W-1:0] pulse_count;
    logic [CFG_W-1:0] extra_pulses;
    logic [CFG_W-1:0] pulse_period;
    logic [CFG_W-1:0] high_span;
  } cfg_t;

endpackage

// ===== rtl/ptsd_ram.sv =====
// Simple dual-port RAM: one write port, one registered read port.
// Holds the squared magnitudes of one frame. No package dependency.
module ptsd_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/ptsd_front.sv =====
// Front end: accepts samples, squares them, stores magnitudes and tracks the peak.
// Depends on ptsd_pkg; writes ptsd_ram and pushes closed frames into ptsd_queue.
module ptsd_front import ptsd_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic signed [SAMPLE_W-1:0] sample_re,
  input  logic signed [SAMPLE_W-1:0] sample_im,
  input  logic                       frame_end,
  input  logic                       frame_done,
  input  logic                       desc_full,
  output logic                       ram_we,
  output logic [ADDR_W-1:0]          ram_waddr,
  output logic [MAG_W-1:0]           ram_wdata,
  output logic                       desc_push,
  output desc_t                      desc
);

  logic                     accept;
  logic                     hold;
  logic                     hold_next;
  logic                     a_valid;
  logic                     a_end;
  logic [SQ_W-1:0]          sq_re;
  logic [SQ_W-1:0]          sq_im;
  logic signed [MAG_W-1:0]  prod_re;
  logic signed [MAG_W-1:0]  prod_im;
  logic [MAG_W-1:0]         mag2;
  logic [MAG_W-1:0]         peak;
  logic [MAG_W-1:0]         peak_next;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;
  logic                     store;

  // Hold off new samples from frame end until the back end has a result
  assign full   = hold | desc_full;
  assign accept = push & ~full;

  always_comb begin
    hold_next = hold;
    if (accept && frame_end) begin
      hold_next = 1'b1;
    end else if (frame_done) begin
      hold_next = 1'b0;
    end
  end

  // Stage A: squares of both components
  assign prod_re = sample_re * sample_re;
  assign prod_im = sample_im * sample_im;

  always_ff @(posedge clk) begin
    if (accept) begin
      sq_re <= prod_re[SQ_W-1:0];
      sq_im <= prod_im[SQ_W-1:0];
      a_end <= frame_end;
    end
  end

  // Stage B: magnitude, store, peak and count
  assign mag2       = MAG_W'(sq_re) + MAG_W'(sq_im);
  assign store      = count < CNT_W'(MAX_FRAME);
  assign peak_next  = (store && (mag2 > peak)) ? mag2 : peak;
  assign count_next = count + CNT_W'(store);

  assign ram_we    = a_valid & store;
  assign ram_waddr = count[ADDR_W-1:0];
  assign ram_wdata = mag2;

  assign desc_push = a_valid & a_end;
  assign desc.n    = count_next;
  assign desc.peak = peak_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      hold    <= 1'b0;
      peak    <= '0;
      count   <= '0;
    end else begin
      a_valid <= accept;
      hold    <= hold_next;
      if (a_valid) begin
        if (a_end) begin
          peak  <= '0;
          count <= '0;
        end else begin
          peak  <= peak_next;
          count <= count_next;
        end
      end
    end
  end

endmodule

// ===== rtl/ptsd_queue.sv =====
// Short queue of closed-frame transactions between front and back.
// Depends on ptsd_pkg for desc_t and the queue depth.
module ptsd_queue import ptsd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  desc_t push_data,
  output logic  full,
  input  logic  pop,
  output logic  valid,
  output desc_t pop_data
);

  desc_t             entry [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wp;
  logic [QPTR_W-1:0] rp;
  logic [QPTR_W:0]   cnt;
  logic              do_push;
  logic              do_pop;

  assign full     = cnt == (QPTR_W+1)'(QUEUE_DEPTH);
  assign valid    = cnt != '0;
  assign pop_data = entry[rp];
  assign do_push  = push & ~full;
  assign do_pop   = pop & valid;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wp] <= push_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) begin
        wp <= wp + 1'b1;
      end
      if (do_pop) begin
        rp <= rp + 1'b1;
      end
      cnt <= cnt + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
    end
  end

endmodule

// ===== rtl/ptsd_back.sv =====
// Back end: length check, edge scan over the stored frame, start computation.
// Depends on ptsd_pkg; reads ptsd_ram and owns the two-entry result queue.
module ptsd_back import ptsd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  logic                desc_valid,
  input  desc_t               desc,
  output logic                desc_pop,
  output logic [ADDR_W-1:0]   ram_raddr,
  input  logic [MAG_W-1:0]    ram_rdata,
  output logic                frame_done,
  output logic                empty,
  input  logic                pop,
  output logic [START_W-1:0]  start_index,
  output logic [STATUS_W-1:0] status
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_NEED  = 6'b000010,
    S_CHECK = 6'b000100,
    S_SCAN  = 6'b001000,
    S_CALC  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t               state;
  logic [CNT_W-1:0]     n;
  logic [THR_W-1:0]     thr;
  logic [NEED_W-1:0]    need;
  logic [CNT_W-1:0]     raddr;
  logic                 dvalid;
  logic [CNT_W-1:0]     didx;
  logic                 prev;
  logic                 first_high;
  logic                 have_rise;
  logic                 have_fall;
  logic [ADDR_W-1:0]    rise;
  logic [ADDR_W-1:0]    fall;
  logic [START_W-1:0]   res_start;
  logic [STATUS_W-1:0]  res_status;

  logic [CFG_W:0]       pulse_sum;
  logic [HI_W-1:0]      mag9;
  logic                 high;
  logic                 rise_hit;
  logic                 fall_hit;
  logic                 scan_last;
  logic signed [START_W:0] start_raw;

  // Result queue
  logic [START_W-1:0]   rb_start  [2];
  logic [STATUS_W-1:0]  rb_status [2];
  logic                 rb_wp;
  logic                 rb_rp;
  logic [1:0]           rb_cnt;
  logic                 rb_push;
  logic                 rb_pop;

  assign desc_pop  = desc_valid && (state == S_IDLE);
  assign ram_raddr = raddr[ADDR_W-1:0];
  assign pulse_sum = {1'b0, cfg.pulse_count} + {1'b0, cfg.extra_pulses};

  // Threshold test: 9*mag2 > 4*peak
  assign mag9 = {ram_rdata, 3'b000} + HI_W'(ram_rdata);
  assign high = mag9 > HI_W'(thr);

  // Edge detection on the sample now being read back
  assign rise_hit  = (didx != '0) && high && !prev && !have_rise;
  assign fall_hit  = (didx != '0) && !high && prev && !have_fall;
  assign scan_last = (didx == n - 1'b1) ||
                     ((have_rise || rise_hit) && (have_fall || fall_hit));

  // Start index, signed before clamping
  assign start_raw = first_high ?
      ($signed({3'b000, fall}) + $signed({3'b000, cfg.pulse_period}) -
       $signed({3'b000, cfg.high_span})) :
      ($signed({3'b000, rise}) + $signed({3'b000, cfg.pulse_period}));

  assign rb_push    = (state == S_EMIT) && (rb_cnt != 2'd2);
  assign frame_done = rb_push;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      dvalid <= 1'b0;
      raddr  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          raddr  <= '0;
          dvalid <= 1'b0;
          if (desc_valid) begin
            n     <= desc.n;
            thr   <= {desc.peak, 2'b00};
            state <= S_NEED;
          end
        end
        S_NEED: begin
          need  <= NEED_W'(pulse_sum) * NEED_W'(cfg.pulse_period);
          state <= S_CHECK;
        end
        S_CHECK: begin
          have_rise <= 1'b0;
          have_fall <= 1'b0;
          if (NEED_W'(n) < need) begin
            res_start  <= '0;
            res_status <= ST_SHORT;
            state      <= S_EMIT;
          end else if (n == '0) begin
            state <= S_CALC;
          end else begin
            // address 0 is on the RAM port now
            raddr  <= raddr + 1'b1;
            didx   <= raddr;
            dvalid <= 1'b1;
            state  <= S_SCAN;
          end
        end
        S_SCAN: begin
          dvalid <= raddr < n;
          didx   <= raddr;
          if (raddr < n) begin
            raddr <= raddr + 1'b1;
          end
          if (dvalid) begin
            prev <= high;
            if (didx == '0) begin
              first_high <= high;
            end
            if (rise_hit) begin
              have_rise <= 1'b1;
              rise      <= didx[ADDR_W-1:0] - 1'b1;
            end
            if (fall_hit) begin
              have_fall <= 1'b1;
              fall      <= didx[ADDR_W-1:0] - 1'b1;
            end
            if (scan_last) begin
              state <= S_CALC;
            end
          end
        end
        S_CALC: begin
          if (!have_rise || !have_fall) begin
            res_start  <= '0;
            res_status <= ST_NO_EDGE;
          end else begin
            res_status <= ST_OK;
            if (start_raw < 0) begin
              res_start <= '0;
            end else if (start_raw > (START_W+1)'(START_MAX)) begin
              res_start <= START_W'(START_MAX);
            end else begin
              res_start <= start_raw[START_W-1:0];
            end
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (rb_push) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Two-entry result queue toward the receiver
  assign empty       = rb_cnt == 2'd0;
  assign rb_pop      = pop & ~empty;
  assign start_index = rb_start[rb_rp];
  assign status      = rb_status[rb_rp];

  always_ff @(posedge clk) begin
    if (rb_push) begin
      rb_start[rb_wp]  <= res_start;
      rb_status[rb_wp] <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rb_wp  <= 1'b0;
      rb_rp  <= 1'b0;
      rb_cnt <= 2'd0;
    end else begin
      if (rb_push) begin
        rb_wp <= ~rb_wp;
      end
      if (rb_pop) begin
        rb_rp <= ~rb_rp;
      end
      rb_cnt <= rb_cnt + 2'(rb_push) - 2'(rb_pop);
    end
  end

endmodule

// ===== rtl/pulse_train_start_detector.sv =====
// Top level of the pulse train start detector: register file and module wiring.
// Depends on ptsd_pkg, ptsd_ram, ptsd_front, ptsd_queue and ptsd_back.
//
// Usage:
//   Samples enter through push/full, one transaction per cycle while full is
//   low; frame_end marks the last sample of a frame. Results leave through
//   empty/pop, one per frame: start_index and status. Registers are written
//   through cfg_valid/cfg_ready (always ready), cfg_index and cfg_data; the
//   user must write them only while the block is idle, which it does not enforce.
//   Flow: after the frame_end transaction, the back end checks the frame
//   length and then scans, reading one stored magnitude per cycle until both
//   edges are found or the frame ends, bounded by the single read port of the
//   magnitude RAM. Full is high from the frame_end transaction until the
//   result enters the output queue.
//   Reset: registers return to 1, 0, 64, 16; peak, count and all queues are
//   cleared. The magnitude RAM is not cleared: only entries of the current
//   frame are read.
//   Receiver stall: the output queue holds two results; when it is full the
//   back end waits with its result and full stays high.
module pulse_train_start_detector import ptsd_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic signed [SAMPLE_W-1:0] sample_re,
  input  logic signed [SAMPLE_W-1:0] sample_im,
  input  logic                       frame_end,
  output logic                       empty,
  input  logic                       pop,
  output logic [START_W-1:0]         start_index,
  output logic [STATUS_W-1:0]        status,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data
);

  cfg_t                cfg;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [MAG_W-1:0]    ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [MAG_W-1:0]    ram_rdata;
  logic                desc_push;
  desc_t               desc_in;
  logic                desc_full;
  logic                desc_pop;
  logic                desc_valid;
  desc_t               desc_out;
  logic                frame_done;

  // Register file
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse_count  <= RST_PULSE_COUNT;
      cfg.extra_pulses <= RST_EXTRA_PULSES;
      cfg.pulse_period <= RST_PULSE_PERIOD;
      cfg.high_span    <= RST_HIGH_SPAN;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PULSE_COUNT:  cfg.pulse_count  <= cfg_data;
        REG_EXTRA_PULSES: cfg.extra_pulses <= cfg_data;
        REG_PULSE_PERIOD: cfg.pulse_period <= cfg_data;
        REG_HIGH_SPAN:    cfg.high_span    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  ptsd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .sample_re  (sample_re),
    .sample_im  (sample_im),
    .frame_end  (frame_end),
    .frame_done (frame_done),
    .desc_full  (desc_full),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .desc_push  (desc_push),
    .desc       (desc_in)
  );

  ptsd_ram #(
    .DEPTH (MAX_FRAME),
    .WIDTH (MAG_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ptsd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (desc_push),
    .push_data (desc_in),
    .full      (desc_full),
    .pop       (desc_pop),
    .valid     (desc_valid),
    .pop_data  (desc_out)
  );

  ptsd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .desc_valid  (desc_valid),
    .desc        (desc_out),
    .desc_pop    (desc_pop),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .frame_done  (frame_done),
    .empty       (empty),
    .pop         (pop),
    .start_index (start_index),
    .status      (status)
  );

endmodule

// ===== rtl/ptsd_checker.sv =====
// Port-level checks for pulse_train_start_detector, attached by bind.
// Depends on ptsd_pkg for widths and status codes.
module ptsd_checker import ptsd_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                push,
  input logic                full,
  input logic                frame_end,
  input logic                empty,
  input logic                pop,
  input logic [START_W-1:0]  start_index,
  input logic [STATUS_W-1:0] status
);

  // Output queue comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  // Closing a frame blocks further samples
  a_end_blocks: assert property (@(posedge clk) disable iff (rst)
    push && !full && frame_end |=> full)
    else $error("sample accepted after frame end before result");

  // Input reopens only when a result is waiting
  a_reopen_result: assert property (@(posedge clk) disable iff (rst)
    $fell(full) |-> !empty)
    else $error("input reopened without a result");

  // Failed frames report start 0
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    !empty && status != ST_OK |-> start_index == '0)
    else $error("nonzero start index on failed frame");

  // A waiting result holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(start_index) && $stable(status))
    else $error("stalled result changed");

endmodule

bind pulse_train_start_detector ptsd_checker u_ptsd_checker (.*);

// ===== test/pulse_train_start_detector_test.sv =====
// Self-checking testbench for the pulse train start detector: queues framed echo samples,
// predicts start index and status for each frame, and compares every result transaction.
// Depends on ptsd_pkg and the pulse_train_start_detector RTL.
module pulse_train_start_detector_test;
  import ptsd_pkg::*;

  // Watchdog limit, set with a wide margin over the slowest legal run
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 16;
  localparam int OVERFLOW_LEN = MAX_FRAME + 4;

  typedef struct {
    logic signed [SAMPLE_W-1:0] re;
    logic signed [SAMPLE_W-1:0] im;
    logic                       last;
  } echo_sample_t;

  typedef struct {
    logic [START_W-1:0]  start;
    logic [STATUS_W-1:0] stat;
  } pulse_start_t;

  // DUT signals; the inputs are known from time zero
  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       push = 1'b0;
  logic                       full;
  logic signed [SAMPLE_W-1:0] sample_re = '0;
  logic signed [SAMPLE_W-1:0] sample_im = '0;
  logic                       frame_end = 1'b0;
  logic                       empty;
  logic                       pop = 1'b0;
  logic [START_W-1:0]         start_index;
  logic [STATUS_W-1:0]        status;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index = REG_PULSE_COUNT;
  logic [CFG_W-1:0]           cfg_data = '0;

  // Stimulus and scoreboard
  echo_sample_t sample_queue[$];
  pulse_start_t expected_starts[$];
  pulse_start_t popped_start;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           error_count = 0;
  int           cycle_count = 0;

  // Predictor state: stored magnitudes, peak, fill count and register copy
  logic [MAG_W-1:0] mag_mem [MAX_FRAME];
  logic [MAG_W-1:0] peak_mag = '0;
  int unsigned      stored = 0;
  logic [CFG_W-1:0] cfg_count = RST_PULSE_COUNT;
  logic [CFG_W-1:0] cfg_extra = RST_EXTRA_PULSES;
  logic [CFG_W-1:0] cfg_period = RST_PULSE_PERIOD;
  logic [CFG_W-1:0] cfg_span = RST_HIGH_SPAN;

  pulse_train_start_detector uut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .sample_re   (sample_re),
    .sample_im   (sample_im),
    .frame_end   (frame_end),
    .empty       (empty),
    .pop         (pop),
    .start_index (start_index),
    .status      (status),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #5 clk = ~clk;

  // High means magnitude above two thirds of the peak, in exact integer form
  function automatic bit above_two_thirds(int unsigned idx);
    longint unsigned m;
    longint unsigned p;
    m = mag_mem[idx];
    p = peak_mag;
    return (9 * m) > (4 * p);
  endfunction

  // Scan the closed frame for the first edges and derive start index and status
  function automatic pulse_start_t locate_pulse_start();
    pulse_start_t res;
    longint       need;
    longint       s;
    bit           prev;
    bit           cur;
    bit           first_high;
    bit           got_rise;
    bit           got_fall;
    int unsigned  rise;
    int unsigned  fall;
    int unsigned  i;
    need = (longint'(cfg_count) + longint'(cfg_extra)) * longint'(cfg_period);
    res.start = '0;
    res.stat = ST_OK;
    got_rise = 1'b0;
    got_fall = 1'b0;
    rise = 0;
    fall = 0;
    if (longint'(stored) < need) begin
      res.stat = ST_SHORT;
    end else begin
      prev = (stored > 0) ? above_two_thirds(0) : 1'b0;
      first_high = prev;
      for (i = 1; i < stored && !(got_rise && got_fall); i++) begin
        cur = above_two_thirds(i);
        if (cur && !prev && !got_rise) begin
          got_rise = 1'b1;
          rise = i - 1;
        end
        if (!cur && prev && !got_fall) begin
          got_fall = 1'b1;
          fall = i - 1;
        end
        prev = cur;
      end
      if (!got_rise || !got_fall) begin
        res.stat = ST_NO_EDGE;
      end else begin
        if (first_high) begin
          s = longint'(fall) + longint'(cfg_period) - longint'(cfg_span);
        end else begin
          s = longint'(rise) + longint'(cfg_period);
        end
        if (s < 0) s = 0;
        if (s > START_MAX) s = START_MAX;
        res.start = START_W'(s);
      end
    end
    peak_mag = '0;
    stored = 0;
    return res;
  endfunction

  // Store one accepted sample; a frame end yields one expected result
  function automatic void absorb_sample(echo_sample_t smp);
    longint           r;
    longint           q;
    logic [MAG_W-1:0] mag;
    r = smp.re;
    q = smp.im;
    mag = MAG_W'(r * r + q * q);
    // samples past the end of storage are dropped, peak untouched
    if (stored < MAX_FRAME) begin
      mag_mem[stored] = mag;
      if (mag > peak_mag) peak_mag = mag;
      stored++;
    end
    if (smp.last) expected_starts.insert(expected_starts.size(), locate_pulse_start());
  endfunction

  // Queue one sample; values are cut to the sample width
  function automatic void add_sample(int re, int im, bit last);
    echo_sample_t smp;
    smp.re = SAMPLE_W'(re);
    smp.im = SAMPLE_W'(im);
    smp.last = last;
    sample_queue.insert(sample_queue.size(), smp);
  endfunction

  // Directed frame from a level string: H high, L low, anything else zero
  function automatic void add_levels(string pat);
    bit last;
    for (int i = 0; i < pat.len(); i++) begin
      last = (i == pat.len() - 1);
      case (pat[i])
        "H": add_sample(20000, -7000, last);
        "L": add_sample(-300, 150, last);
        default: add_sample(0, 0, last);
      endcase
    end
  endfunction

  // Pulse train echo with random amplitude, phase, sign and a few glitches
  function automatic void add_pulse_frame(int unsigned n);
    int unsigned per;
    int unsigned span;
    int unsigned phase;
    int          amp;
    int          a;
    int          b;
    bit          hi;
    per = cfg_period;
    span = cfg_span;
    if (per < 2) span = 1;
    else if (span < 1) span = 1;
    else if (span > per - 1) span = per - 1;
    phase = $urandom_range(per - 1, 0);
    amp = $urandom_range(32767, 64);
    for (int unsigned i = 0; i < n; i++) begin
      hi = ((i + phase) % per) < span;
      if ($urandom_range(99, 0) < 3) hi = !hi;
      if (hi) begin
        a = amp - $urandom_range(amp / 8, 0);
        b = $urandom_range(amp / 8, 0);
      end else begin
        a = $urandom_range(amp / 4, 0);
        b = $urandom_range(amp / 4, 0);
      end
      if ($urandom_range(1, 0)) a = -a;
      if ($urandom_range(1, 0)) b = -b;
      add_sample(a, b, i == n - 1);
    end
  endfunction

  // Random frames under the current settings until the quota of samples is queued
  function automatic void queue_random_frames(int unsigned quota);
    int unsigned added;
    int unsigned n;
    int unsigned need;
    int unsigned pick;
    logic signed [SAMPLE_W-1:0] level;
    added = 0;
    need = (int'(cfg_count) + int'(cfg_extra)) * int'(cfg_period);
    while (added < quota) begin
      pick = $urandom_range(99, 0);
      if (pick < 70) begin
        // well-formed train, long enough for an ok status
        n = need + $urandom_range(2 * cfg_period, 0);
        add_pulse_frame(n);
      end else if (pick < 85) begin
        // full-range noise
        n = $urandom_range(need + 8, 1);
        for (int unsigned i = 0; i < n; i++) begin
          add_sample(int'($urandom), int'($urandom), i == n - 1);
        end
      end else if (pick < 95) begin
        // truncated train
        n = (need > 1) ? $urandom_range(need - 1, 1) : 1;
        add_pulse_frame(n);
      end else begin
        // flat frame, zero or constant, has no edges
        n = $urandom_range(need + 4, 1);
        level = $urandom_range(1, 0) ? SAMPLE_W'($urandom) : '0;
        for (int unsigned i = 0; i < n; i++) begin
          add_sample(int'(level), int'(level), i == n - 1);
        end
      end
      added += n;
    end
  endfunction

  task automatic wait_drained();
    while (sample_queue.size() != 0 || expected_starts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic await_cfg_transaction();
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write all four registers back to back while the block is idle
  task automatic set_config(int count, int extra, int period, int span);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= REG_PULSE_COUNT;
    cfg_data <= CFG_W'(count);
    await_cfg_transaction();
    cfg_count = CFG_W'(count);
    cfg_index <= REG_EXTRA_PULSES;
    cfg_data <= CFG_W'(extra);
    await_cfg_transaction();
    cfg_extra = CFG_W'(extra);
    cfg_index <= REG_PULSE_PERIOD;
    cfg_data <= CFG_W'(period);
    await_cfg_transaction();
    cfg_period = CFG_W'(period);
    cfg_index <= REG_HIGH_SPAN;
    cfg_data <= CFG_W'(span);
    await_cfg_transaction();
    cfg_span = CFG_W'(span);
    cfg_valid <= 1'b0;
  endtask

  // Driver: one sample transaction per accepted edge, random idle cycles
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        absorb_sample(sample_queue.pop_front());
      end
      if (sample_queue.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        push <= 1'b1;
        sample_re <= sample_queue[0].re;
        sample_im <= sample_queue[0].im;
        frame_end <= sample_queue[0].last;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Monitor: compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_starts.size() == 0) begin
          $error("unexpected result: start_index %0d status %0d", start_index, status);
          error_count++;
        end else begin
          popped_start = expected_starts.pop_front();
          if (start_index !== popped_start.start) begin
            $error("start_index: expected %0d, actual %0d", popped_start.start, start_index);
            error_count++;
          end
          if (status !== popped_start.stat) begin
            $error("status: expected %0d, actual %0d", popped_start.stat, status);
            error_count++;
          end
        end
      end
      pop <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int send_pct [4];
    int recv_pct [4];
    int unsigned per;
    int a;
    int b;
    send_pct = '{0, 75, 0, 9};
    recv_pct = '{0, 0, 75, 9};

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: single extreme sample under reset settings is too short
    add_sample(-32768, -32768, 1'b1);

    // Short period: all-zero frame, first-high frame, first-low frame, extremes
    set_config(1, 0, 4, 2);
    add_levels("ZZZZZ");
    add_levels("HHLLHL");
    add_levels("LHHLL");
    add_sample(32767, 32767, 1'b0);
    add_sample(-32768, -32768, 1'b0);
    add_sample(0, 1, 1'b0);
    add_sample(-1, 0, 1'b1);

    // High span longer than period saturates the start at zero
    set_config(1, 0, 1, 4095);
    add_levels("HLH");

    // Register maxima: every frame is too short
    set_config(4095, 4095, 4095, 0);
    add_sample(0, 0, 1'b0);
    add_sample(5, -5, 1'b1);

    // Random phases, two settings each, across the idle mixes
    for (int ph = 0; ph < 4; ph++) begin
      for (int sub = 0; sub < 2; sub++) begin
        per = $urandom_range(10, 1);
        set_config($urandom_range(2, 1), $urandom_range(1, 0), per,
                   ($urandom_range(9, 0) == 0) ? per + $urandom_range(20, 1)
                                               : $urandom_range(per, 0));
        send_idle_pct = send_pct[ph];
        recv_stall_pct = recv_pct[ph];
        queue_random_frames(195);
      end
    end

    // Overflow frame: pulse near the end of storage, loud samples past it ignored
    set_config(int'(RST_PULSE_COUNT), int'(RST_EXTRA_PULSES), int'(RST_PULSE_PERIOD),
               int'(RST_HIGH_SPAN));
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < OVERFLOW_LEN; i++) begin
      if (i >= MAX_FRAME) begin
        a = 32767;
        b = -32768;
      end else if (i >= 3950 && i < 3966) begin
        a = 20000 - $urandom_range(500, 0);
        b = -3000;
      end else begin
        a = $urandom_range(200, 0) - 100;
        b = $urandom_range(200, 0) - 100;
      end
      add_sample(a, b, i == OVERFLOW_LEN - 1);
    end

    // Drain and give any stray result time to show up
    wait_drained();
    repeat (64) @(posedge clk);
    if (error_count == 0 && expected_starts.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ptsd_pkg.sv
rtl/ptsd_ram.sv
rtl/ptsd_front.sv
rtl/ptsd_queue.sv
rtl/ptsd_back.sv
rtl/pulse_train_start_detector.sv
rtl/ptsd_checker.sv
test/pulse_train_start_detector_test.sv
